### hw/rtl/hea_pkg.sv
// ----------------------------------------------------------------------------
// hea_pkg
// Shared constants, log table and command/status types of the entropy core.
// ----------------------------------------------------------------------------
package hea_pkg;

	localparam int MaxItemsDef  = 65536;
	localparam int CountBitsDef = 24;
	localparam int FracBitsDef  = 16;

	localparam int CountW = 24;
	localparam int SumW   = 48;
	localparam int WsumW  = 64;
	localparam int OutW   = 22;
	localparam logic [27:0] Ln2Q28 = 28'd186065280;

	localparam int RomW = 31;
	localparam int RomN = 33;

	typedef enum logic [2:0] {
		OP_IDLE     = 3'd0,
		OP_LOAD     = 3'd1,
		OP_LOG      = 3'd2,
		OP_ACC      = 3'd3,
		OP_DIV      = 3'd4,
		OP_FIN      = 3'd5,
		OP_LOG_SUM  = 3'd6
	} op_t;

	typedef struct packed {
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic nonzero;
		logic sum_zero;
		logic log_done;
		logic div_done;
	} stat_t;

	// log2(1 + i/32) in Q30 by repeated squaring, entry i at bits i*31
	function automatic logic [RomN*RomW-1:0] log_rom_build();
		logic [RomN*RomW-1:0] t;
		logic [63:0] y;
		logic [RomW-1:0] a;
		t = '0;
		for (int i = 0; i < 32; i++) begin
			y = 64'h8000_0000 + (64'(i) << 26);
			a = '0;
			for (int b = 0; b < 30; b++) begin
				y = (y * y) >> 31;
				a = a << 1;
				if (y >= 64'h1_0000_0000) begin
					a[0] = 1'b1;
					y = y >> 1;
				end
			end
			t[i*RomW +: RomW] = a;
		end
		t[32*RomW +: RomW] = 31'h4000_0000;
		return t;
	endfunction

	localparam logic [RomN*RomW-1:0] LogRom = log_rom_build();

endpackage

### hw/rtl/hea_ctrl.sv
// ----------------------------------------------------------------------------
// hea_ctrl
// Sequencer: load, log, accumulate per nonzero item; log, divide, finish last.
// ----------------------------------------------------------------------------
module hea_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            last_item,
	input  hea_pkg::stat_t  stat,
	output hea_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [2:0] {
		S_IDLE, S_ITEM_LOG, S_ITEM_ACC, S_END_LOG, S_DIV, S_FIN
	} state_t;

	state_t state_q;
	logic   last_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.op   = hea_pkg::OP_IDLE;
		done     = 1'b0;
		case (state_q)
			S_IDLE:     cmd.op = start ? hea_pkg::OP_LOAD : hea_pkg::OP_IDLE;
			S_ITEM_LOG: cmd.op = stat.nonzero ? hea_pkg::OP_LOG : hea_pkg::OP_IDLE;
			S_ITEM_ACC: cmd.op = hea_pkg::OP_ACC;
			S_END_LOG:  cmd.op = stat.sum_zero ? hea_pkg::OP_IDLE : hea_pkg::OP_LOG_SUM;
			S_DIV:      cmd.op = hea_pkg::OP_DIV;
			S_FIN: begin
				cmd.op = hea_pkg::OP_FIN;
				done   = 1'b1;
			end
			default:    cmd.op = hea_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						last_q  <= last_item;
						state_q <= S_ITEM_LOG;
					end
				end
				S_ITEM_LOG: begin
					if (!stat.nonzero) state_q <= last_q ? S_END_LOG : S_IDLE;
					else if (stat.log_done) state_q <= S_ITEM_ACC;
				end
				S_ITEM_ACC: state_q <= last_q ? S_END_LOG : S_IDLE;
				S_END_LOG: begin
					if (stat.sum_zero) state_q <= S_FIN;
					else if (stat.log_done) state_q <= S_DIV;
				end
				S_DIV:   if (stat.div_done) state_q <= S_FIN;
				S_FIN:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("transfer not taken");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done while idle");

endmodule

### hw/rtl/hea_dp.sv
// ----------------------------------------------------------------------------
// hea_dp
// Datapath: multi-cycle log unit, accumulators, restoring divider, output.
// ----------------------------------------------------------------------------
module hea_dp #(
	parameter int COUNT_BITS = hea_pkg::CountBitsDef,
	parameter int FRAC_BITS  = hea_pkg::FracBitsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hea_pkg::cmd_t             cmd,
	input  logic [hea_pkg::CountW-1:0] count_value,
	output hea_pkg::stat_t            stat,
	output logic [hea_pkg::OutW-1:0]  entropy_nats,
	output logic                      all_zero,
	output logic                      saturated
);

	localparam int CountW  = hea_pkg::CountW;
	localparam int SumW    = hea_pkg::SumW;
	localparam int WsumW   = hea_pkg::WsumW;
	localparam int RomW    = hea_pkg::RomW;
	localparam int DivCntW = $clog2(WsumW + 1);
	localparam int DnSh    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int UpSh    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [WsumW-1:0] RndAdd = (WsumW'(1) << DnSh) >> 1;
	localparam logic [CountW-1:0] CntMask = (COUNT_BITS >= CountW) ? '1
		: CountW'((64'd1 << COUNT_BITS) - 64'd1);

	logic [CountW-1:0]     cnt_q;
	logic [SumW-1:0]       sum_q;
	logic [WsumW-1:0]      wsum_q;
	logic                  ovf_q;

	// log unit: step 0 load operand, 1 normalise, 2 interpolate, 3 scale and round
	logic [1:0]  lstep_q;
	logic [5:0]  lexp_q;
	logic [SumW-1:0] lmant_q;
	logic [4:0]  lidx_q;
	logic [15:0] lr_q;
	logic [36:0] l2_q;
	logic [31:0] ln_q;
	logic        log_on;
	logic        log_done;

	logic [5:0]      msb;
	logic [30:0]     rlo, rhi;
	logic [47:0]     dmul;

	always_comb begin
		msb = '0;
		for (int k = 0; k < SumW; k++) if (lmant_q[k]) msb = 6'(k);
		rlo  = hea_pkg::LogRom[RomW*int'(lidx_q) +: RomW];
		rhi  = hea_pkg::LogRom[RomW*(int'(lidx_q) + 1) +: RomW];
		dmul = 48'(rhi - rlo) * 48'(lr_q);
	end

	assign log_on   = (cmd.op == hea_pkg::OP_LOG) || (cmd.op == hea_pkg::OP_LOG_SUM);
	assign log_done = log_on && (lstep_q == 2'd3);

	// divider
	logic [WsumW-1:0] dq_q;
	logic [SumW-1:0]  drem_q;
	logic [DivCntW-1:0] dcnt_q;
	logic             dbusy_q;
	logic [SumW:0]    dtrial;
	assign dtrial = {drem_q, dq_q[WsumW-1]};

	logic [WsumW-1:0] diff, v;
	always_comb begin
		diff = (WsumW'(ln_q) > dq_q) ? WsumW'(ln_q) - dq_q : '0;
		if (FRAC_BITS >= 16) v = (diff + RndAdd) >> DnSh;
		else v = diff << UpSh;
	end

	assign stat.nonzero  = (cnt_q != '0);
	assign stat.sum_zero = (sum_q == '0);
	assign stat.log_done = log_done;
	assign stat.div_done = dbusy_q && (dcnt_q == DivCntW'(WsumW));

	logic [SumW:0]    nsum;
	logic [WsumW:0]   nw;
	logic [55:0]      tprod;
	logic [WsumW-1:0] term;
	assign tprod = {32'd0, cnt_q} * {24'd0, ln_q};
	assign term  = {8'd0, tprod};
	assign nsum  = {1'b0, sum_q} + (SumW+1)'(cnt_q);
	assign nw    = {1'b0, wsum_q} + {1'b0, term};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			wsum_q  <= '0;
			ovf_q   <= 1'b0;
			lstep_q <= '0;
			lexp_q  <= '0;
			lmant_q <= '0;
			lidx_q  <= '0;
			lr_q    <= '0;
			l2_q    <= '0;
			ln_q    <= '0;
			dq_q    <= '0;
			drem_q  <= '0;
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
			entropy_nats <= '0;
			all_zero  <= 1'b0;
			saturated <= 1'b0;
		end else begin
			case (cmd.op)
				hea_pkg::OP_LOAD: begin
					cnt_q   <= count_value & CntMask;
					lstep_q <= '0;
				end
				hea_pkg::OP_LOG, hea_pkg::OP_LOG_SUM: begin
					lstep_q <= lstep_q + 2'd1;
					case (lstep_q)
						2'd0: begin
							lmant_q <= (cmd.op == hea_pkg::OP_LOG_SUM) ? sum_q : SumW'(cnt_q);
						end
						2'd1: begin
							lexp_q <= msb;
							lidx_q <= 5'((lmant_q << (SumW - 1 - msb)) >> (SumW - 6));
							lr_q   <= 16'((lmant_q << (SumW - 1 - msb)) >> (SumW - 22));
						end
						2'd2: begin
							l2_q <= (37'(lexp_q) << 30) + 37'(rlo) + 37'(dmul >> 16);
						end
						default: begin
							ln_q <= 32'(((65'(l2_q) * 65'(hea_pkg::Ln2Q28))
								+ (65'(1) << (57 - FRAC_BITS))) >> (58 - FRAC_BITS));
						end
					endcase
				end
				hea_pkg::OP_ACC: begin
					if (nsum[SumW]) begin
						sum_q <= '1;
						ovf_q <= 1'b1;
					end else sum_q <= nsum[SumW-1:0];
					if (nw[WsumW]) begin
						wsum_q <= '1;
						ovf_q  <= 1'b1;
					end else wsum_q <= nw[WsumW-1:0];
				end
				hea_pkg::OP_DIV: begin
					if (!dbusy_q) begin
						dbusy_q <= 1'b1;
						dcnt_q  <= '0;
						dq_q    <= wsum_q;
						drem_q  <= '0;
					end else if (dcnt_q != DivCntW'(WsumW)) begin
						dcnt_q <= dcnt_q + DivCntW'(1);
						if (dtrial >= {1'b0, sum_q}) begin
							drem_q <= dtrial[SumW-1:0] - sum_q;
							dq_q   <= {dq_q[WsumW-2:0], 1'b1};
						end else begin
							drem_q <= dtrial[SumW-1:0];
							dq_q   <= {dq_q[WsumW-2:0], 1'b0};
						end
					end
				end
				hea_pkg::OP_FIN: begin
					dbusy_q   <= 1'b0;
					all_zero  <= (sum_q == '0);
					saturated <= ovf_q;
					if (sum_q == '0) entropy_nats <= '0;
					else if (v > WsumW'({hea_pkg::OutW{1'b1}})) entropy_nats <= '1;
					else entropy_nats <= v[hea_pkg::OutW-1:0];
					sum_q  <= '0;
					wsum_q <= '0;
					ovf_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == hea_pkg::OP_FIN |=> sum_q == '0 && wsum_q == '0)
		else $error("accumulators not cleared");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> (sum_q == '1 || wsum_q == '1))
		else $error("overflow without saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> dbusy_q)
		else $error("divider done while idle");

endmodule

### hw/rtl/histogram_entropy_accumulator_core.sv
// ----------------------------------------------------------------------------
// histogram_entropy_accumulator_core
// Shannon entropy in nats over a stream of histogram counts.
//
// channel  | signals                                  | handshake
// input    | count_value, last_item                   | start & !busy
// result   | entropy_nats, all_zero, saturated        | done, one cycle
//
// A nonzero item runs load, the four log steps and accumulate; a zero item
// runs load and the zero check only. The last item adds four log steps on the
// sum, the bit-serial divider and finish, or finish alone when the sum is zero;
// done follows in the cycle after finish. Reset clears all accumulators. The
// receiver cannot stall; busy holds off the sender.
// ----------------------------------------------------------------------------
module histogram_entropy_accumulator_core #(
	parameter int COUNT_BITS = hea_pkg::CountBitsDef,
	parameter int FRAC_BITS  = hea_pkg::FracBitsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [hea_pkg::CountW-1:0] count_value,
	input  logic                       last_item,
	output logic                       done,
	output logic [hea_pkg::OutW-1:0]   entropy_nats,
	output logic                       all_zero,
	output logic                       saturated
);

	hea_pkg::cmd_t  cmd;
	hea_pkg::stat_t stat;
	logic           fin;
	logic           done_q;

	hea_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_item(last_item),
		.stat(stat), .cmd(cmd), .busy(busy), .done(fin)
	);

	hea_dp #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .count_value(count_value),
		.stat(stat), .entropy_nats(entropy_nats), .all_zero(all_zero),
		.saturated(saturated)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= fin;
	end

	assign done = done_q;

endmodule
